// ===== design/sktr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the scan-code translation table for the tracker.
package sktr_pkg;

  localparam int HELD_DEPTH = 128;
  localparam int IDX_W      = $clog2(HELD_DEPTH);
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
  localparam int CODE_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 9;
  localparam int CMD_W      = 2;

  localparam logic [CODE_W-1:0] PASS_MAX = 7'h58;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POP     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  // Broadcast from the controller to every cell; steady for a whole walk.
  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

  // Walk token handed from cell to cell.
  typedef struct packed {
    logic              act;
    logic              found;
    logic [CODE_W-1:0] val;
  } tok_t;

  function automatic logic [KEY_W-1:0] translate(input logic [CODE_W-1:0] c);
    logic [KEY_W-1:0] k;
    k = {{(KEY_W-CODE_W){1'b0}}, c};
    if (c > PASS_MAX) begin
      case (c)
        7'h59:   k = 9'd96;
        7'h5a:   k = 9'd97;
        7'h5b:   k = 9'd98;
        7'h5c:   k = 9'd210;
        7'h5d:   k = 9'd100;
        7'h5e:   k = 9'd102;
        7'h5f:   k = 9'd103;
        7'h60:   k = 9'd104;
        7'h61:   k = 9'd105;
        7'h62:   k = 9'd106;
        7'h63:   k = 9'd107;
        7'h64:   k = 9'd108;
        7'h65:   k = 9'd109;
        7'h66:   k = 9'd110;
        7'h67:   k = 9'd111;
        7'h68:   k = 9'd119;
        7'h69:   k = 9'd125;
        7'h6a:   k = 9'd126;
        7'h6b:   k = 9'd139;
        7'h6c:   k = 9'h19b;
        default: k = {{(KEY_W-CODE_W){1'b0}}, c};
      endcase
    end
    return k;
  endfunction

endpackage

// ===== design/sktr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scan input and key results.
interface sktr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sktr_pkg::CMD_W-1:0]   command;
  logic [sktr_pkg::BYTE_W-1:0]  scan_code;

  modport source (output valid, output command, output scan_code, input ready);
  modport sink   (input valid, input command, input scan_code, output ready);
endinterface

interface sktr_out_if;
  logic                        valid;
  logic                        ready;
  logic [sktr_pkg::KEY_W-1:0]  keycode;
  logic                        is_press;
  logic                        list_empty;

  modport source (output valid, output keycode, output is_press, output list_empty,
                  input ready);
  modport sink   (input valid, input keycode, input is_press, input list_empty,
                  output ready);
endinterface

// ===== design/sktr_cell.sv =====
`timescale 1ns / 1ps
// One held-key slot: compares, shifts or loads as the walk token passes.
module sktr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sktr_pkg::IDX_W-1:0]    idx_i,
  input  sktr_pkg::cell_ctrl_t          ctrl_i,
  input  sktr_pkg::tok_t                tok_i,
  input  logic [sktr_pkg::CODE_W-1:0]   nxt_i,
  output sktr_pkg::tok_t                tok_o,
  output logic [sktr_pkg::CODE_W-1:0]   dat_o
);

  logic [sktr_pkg::CODE_W-1:0] dat_q, dat_d;
  sktr_pkg::tok_t              tok_q, tok_d;
  logic [sktr_pkg::CNT_W-1:0]  pos;
  logic                        in_list;
  logic                        at_tail;
  logic                        at_top;
  logic                        match;
  logic                        found;

  assign pos     = sktr_pkg::CNT_W'(idx_i);
  assign in_list = pos < ctrl_i.count;
  assign at_tail = pos == ctrl_i.count;
  assign at_top  = (pos + sktr_pkg::CNT_W'(1)) == ctrl_i.count;
  assign match   = tok_i.act && in_list && (dat_q == ctrl_i.code) &&
                   (ctrl_i.op != sktr_pkg::OP_POP);
  assign found   = tok_i.found | match;

  always_comb begin
    dat_d = dat_q;
    if (tok_i.act) begin
      case (ctrl_i.op)
        // close the gap: every slot from the match on takes its upper neighbour
        sktr_pkg::OP_RELEASE: if (found && in_list) dat_d = nxt_i;
        sktr_pkg::OP_PRESS:   if (at_tail && !tok_i.found) dat_d = ctrl_i.code;
        default:              dat_d = dat_q;
      endcase
    end
  end

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = found;
    if (tok_i.act && (ctrl_i.op == sktr_pkg::OP_POP) && at_top) tok_d.val = dat_q;
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign dat_o = dat_q;

endmodule

// ===== design/sktr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: takes input beats, launches walks along the cells, drives results.
module sktr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sktr_in_if.sink               in_i,
  sktr_out_if.source            out_o,
  input  sktr_pkg::tok_t        tok_end_i,
  output sktr_pkg::tok_t        tok_start_o,
  output sktr_pkg::cell_ctrl_t  ctrl_o
);

  sktr_pkg::state_e              state_q, state_d;
  sktr_pkg::op_e                 op_q, op_d;
  logic [sktr_pkg::CODE_W-1:0]   code_q, code_d;
  logic [sktr_pkg::KEY_W-1:0]    key_q, key_d;
  logic                          press_q, press_d;
  logic                          empty_q, empty_d;
  logic [sktr_pkg::CNT_W-1:0]    count_q, count_d;
  logic [sktr_pkg::BYTE_W-1:0]   last_q, last_d;
  logic                          start_q, start_d;
  logic                          ovalid_q, ovalid_d;
  logic [sktr_pkg::KEY_W-1:0]    okey_q, okey_d;
  logic                          opress_q, opress_d;
  logic                          oempty_q, oempty_d;

  logic                          in_fire;
  logic                          out_free;
  logic                          scan_press;
  logic                          scan_take;
  logic [sktr_pkg::CODE_W-1:0]   scan_c;

  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign scan_c     = in_i.scan_code[sktr_pkg::CODE_W-1:0];
  assign scan_press = !in_i.scan_code[sktr_pkg::BYTE_W-1];
  // drop auto-repeat makes and the null code
  assign scan_take  = !(scan_press && (in_i.scan_code == last_q)) &&
                      (scan_c != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sktr_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (sktr_pkg::cmd_e'(in_i.command))
            sktr_pkg::CMD_SCAN: if (scan_take) state_d = sktr_pkg::ST_WALK;
            sktr_pkg::CMD_POP:  state_d = (count_q == '0) ? sktr_pkg::ST_DONE
                                                           : sktr_pkg::ST_WALK;
            default:            state_d = sktr_pkg::ST_IDLE;
          endcase
        end
      end
      sktr_pkg::ST_WALK: if (tok_end_i.act) state_d = sktr_pkg::ST_DONE;
      sktr_pkg::ST_DONE: if (out_free) state_d = sktr_pkg::ST_IDLE;
      default:           state_d = sktr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    code_d   = code_q;
    key_d    = key_q;
    press_d  = press_q;
    empty_d  = empty_q;
    count_d  = count_q;
    last_d   = last_q;
    start_d  = 1'b0;
    ovalid_d = ovalid_q && !out_o.ready;
    okey_d   = okey_q;
    opress_d = opress_q;
    oempty_d = oempty_q;
    case (state_q)
      sktr_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (sktr_pkg::cmd_e'(in_i.command))
            sktr_pkg::CMD_SCAN: begin
              if (scan_take) begin
                last_d  = in_i.scan_code;
                code_d  = scan_c;
                key_d   = sktr_pkg::translate(scan_c);
                press_d = scan_press;
                empty_d = 1'b0;
                op_d    = scan_press ? sktr_pkg::OP_PRESS : sktr_pkg::OP_RELEASE;
                start_d = 1'b1;
              end
            end
            sktr_pkg::CMD_POP: begin
              op_d    = sktr_pkg::OP_POP;
              press_d = 1'b0;
              if (count_q == '0) begin
                key_d   = '0;
                empty_d = 1'b1;
              end else begin
                empty_d = 1'b0;
                start_d = 1'b1;
              end
            end
            sktr_pkg::CMD_CLEAR: begin
              last_d  = '0;
              count_d = '0;
            end
            default: begin
              last_d = last_q;
            end
          endcase
        end
      end
      sktr_pkg::ST_WALK: begin
        if (tok_end_i.act) begin
          case (op_q)
            sktr_pkg::OP_PRESS: begin
              if (!tok_end_i.found && (count_q < sktr_pkg::CNT_W'(sktr_pkg::HELD_DEPTH)))
                count_d = count_q + sktr_pkg::CNT_W'(1);
            end
            sktr_pkg::OP_RELEASE: begin
              if (tok_end_i.found) count_d = count_q - sktr_pkg::CNT_W'(1);
            end
            sktr_pkg::OP_POP: begin
              count_d = count_q - sktr_pkg::CNT_W'(1);
              key_d   = sktr_pkg::translate(tok_end_i.val);
            end
            default: count_d = count_q;
          endcase
        end
      end
      sktr_pkg::ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okey_d   = key_q;
          opress_d = press_q;
          oempty_d = empty_q;
        end
      end
      default: start_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sktr_pkg::ST_IDLE;
      count_q  <= '0;
      last_q   <= '0;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
      op_q     <= sktr_pkg::OP_PRESS;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      last_q   <= last_d;
      start_q  <= start_d;
      ovalid_q <= ovalid_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    key_q    <= key_d;
    press_q  <= press_d;
    empty_q  <= empty_d;
    okey_q   <= okey_d;
    opress_q <= opress_d;
    oempty_q <= oempty_d;
  end

  assign in_i.ready        = state_q == sktr_pkg::ST_IDLE;
  assign out_o.valid       = ovalid_q;
  assign out_o.keycode     = okey_q;
  assign out_o.is_press    = opress_q;
  assign out_o.list_empty  = oempty_q;

  assign tok_start_o.act   = start_q;
  assign tok_start_o.found = 1'b0;
  assign tok_start_o.val   = '0;

  assign ctrl_o.op    = op_q;
  assign ctrl_o.code  = code_q;
  assign ctrl_o.count = count_q;

endmodule

// ===== design/scancode_keycode_tracker.sv =====
`timescale 1ns / 1ps
// Top level: scan-code to key-number tracker with a chain of held-key cells.
// A dropped byte, clear or unused command gives no beat.
// A pop on an empty list gives its beat without a walk, once the output register is free.
// Any other item walks a token along all HELD_DEPTH cells, one cell a cycle; the input
// takes no new item until the current item's beat is in the output register.
// Reset clears the last byte, the held count and the output valid flag; cell tokens are reset, cell data is not.
module scancode_keycode_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  sktr_in_if.sink      in_i,
  sktr_out_if.source   out_o
);

  sktr_pkg::tok_t               tok   [sktr_pkg::HELD_DEPTH+1];
  logic [sktr_pkg::CODE_W-1:0]  dat   [sktr_pkg::HELD_DEPTH];
  sktr_pkg::cell_ctrl_t         ctrl;

  sktr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .tok_end_i   (tok[sktr_pkg::HELD_DEPTH]),
    .tok_start_o (tok[0]),
    .ctrl_o      (ctrl)
  );

  for (genvar i = 0; i < sktr_pkg::HELD_DEPTH; i++) begin : g_cell
    logic [sktr_pkg::CODE_W-1:0] nxt;
    if (i == sktr_pkg::HELD_DEPTH - 1) begin : g_last
      assign nxt = dat[i];
    end else begin : g_mid
      assign nxt = dat[i+1];
    end

    sktr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (sktr_pkg::IDX_W'(i)),
      .ctrl_i (ctrl),
      .tok_i  (tok[i]),
      .nxt_i  (nxt),
      .tok_o  (tok[i+1]),
      .dat_o  (dat[i])
    );
  end

endmodule

// ===== design/sktr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the tracker's result channel, bound to the top level.
module sktr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sktr_pkg::KEY_W-1:0]  keycode_i,
  input logic                        is_press_i,
  input logic                        list_empty_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(keycode_i) && $stable(is_press_i) && $stable(list_empty_i))
    else $error("result beat changed while stalled");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && list_empty_i |-> (keycode_i == '0) && !is_press_i)
    else $error("empty pop must carry keycode 0 as a release");

  a_press_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_press_i |-> !list_empty_i && (keycode_i != '0))
    else $error("press beat with null key or empty flag");

  a_release_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_press_i && !list_empty_i |-> keycode_i != '0)
    else $error("release beat with null key");

endmodule

bind scancode_keycode_tracker sktr_checker u_sktr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .keycode_i    (out_o.keycode),
  .is_press_i   (out_o.is_press),
  .list_empty_i (out_o.list_empty)
);
